@@ hdl/trpd_pkg.sv @@
// shared types and constants for the trimmed row pixel decoder
`timescale 1ns / 1ps
`default_nettype none

package trpd_pkg;

    localparam int DIM_W       = 13;  // width, height and run length
    localparam int COL_W       = 14;  // raw byte position, reaches the padded stride
    localparam int TRAIL_W     = 7;   // largest trailing count is 15 << 3
    localparam int PIX_W       = 8;
    localparam int ZC_W        = 24;
    localparam int TABLE_DEPTH = 256;
    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 13;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_TABLE = 2'd1,
        OP_START = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH     = 3'd0,
        REG_IMAGE_HEIGHT    = 3'd1,
        REG_COMPRESSED_MODE = 3'd2,
        REG_LEADING_SHIFT   = 3'd3,
        REG_TRAILING_SHIFT  = 3'd4,
        REG_REMAP_ENABLE    = 3'd5
    } reg_idx_t;

    // configuration as the front sees it, width and height already clamped
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic             compressed;
        logic [1:0]       lead_shift;
        logic [1:0]       trail_shift;
        logic             remap;
    } cfg_t;

    // up to two runs caused by one request; the second run is always zero valued
    typedef struct packed {
        logic [PIX_W-1:0] pixel0;
        logic [DIM_W-1:0] len0;
        logic             row_end0;
        logic             image_end0;
        logic             two;
        logic [DIM_W-1:0] len1;
        logic             row_end1;
        logic             image_end1;
        logic [ZC_W-1:0]  zero_count;
    } entry_t;

endpackage

`default_nettype wire

@@ hdl/trpd_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module trpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/trpd_front.sv @@
// front end: accepts requests, tracks row state and builds run entries
`timescale 1ns / 1ps
`default_nettype none

module trpd_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire trpd_pkg::cfg_t                cfg,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    operation,
    input  wire logic [trpd_pkg::PIX_W-1:0]    byte_value,
    output logic                               ram_we,
    output logic                               ram_re,
    input  wire logic [trpd_pkg::PIX_W-1:0]    ram_rdata,
    input  wire logic                          q_full,
    output logic                               push,
    output trpd_pkg::entry_t                   push_entry
);

    localparam int DW = trpd_pkg::DIM_W;
    localparam int CW = trpd_pkg::COL_W;
    localparam int TW = trpd_pkg::TRAIL_W;
    localparam int ZW = trpd_pkg::ZC_W;

    logic [DW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic          eh_reg, eh_next;
    logic [DW-1:0] vl_reg, vl_next;
    logic [TW-1:0] tp_reg, tp_next;
    logic [ZW-1:0] zc_reg, zc_next;
    logic          done_reg, done_next;

    logic             stage_valid_reg, stage_valid_next;
    trpd_pkg::entry_t stage_reg;
    logic             stage_map_reg;

    logic             accept;
    logic             finish;
    logic             has_res;
    logic             res_map;
    trpd_pkg::entry_t res;

    logic [TW-1:0] lead_raw, trail_raw;
    logic [DW-1:0] lead, rem, trail, vis;
    logic [DW-1:0] row_inc;
    logic [CW-1:0] col_inc, stride, w_col;
    logic          last_row;

    assign push     = stage_valid_reg && !q_full;
    assign in_stall = stage_valid_reg && q_full;
    assign accept   = in_valid && !in_stall;

    assign ram_we = accept && (operation == trpd_pkg::OP_TABLE);
    assign ram_re = accept && (operation == trpd_pkg::OP_BYTE);

    // header counts, clamped to the width and to what the leading run leaves
    assign lead_raw  = TW'({3'b000, byte_value[3:0]} << cfg.lead_shift);
    assign trail_raw = TW'({3'b000, byte_value[7:4]} << cfg.trail_shift);
    assign lead      = (DW'(lead_raw) > cfg.width) ? cfg.width : DW'(lead_raw);
    assign rem       = cfg.width - lead;
    assign trail     = (DW'(trail_raw) > rem) ? rem : DW'(trail_raw);
    assign vis       = rem - trail;

    assign row_inc  = row_reg + DW'(1);
    assign last_row = ({1'b0, row_reg} + (DW+1)'(1)) >= {1'b0, cfg.height};
    assign w_col    = CW'(cfg.width);
    assign stride   = (w_col + CW'(3)) & ~CW'(3);
    assign col_inc  = col_reg + CW'(1);

    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        eh_next   = eh_reg;
        vl_next   = vl_reg;
        tp_next   = tp_reg;
        zc_next   = zc_reg;
        done_next = done_reg;
        finish    = 1'b0;
        has_res   = 1'b0;
        res_map   = 1'b0;
        res       = '0;

        if (accept)
        begin
            unique case (operation)
                trpd_pkg::OP_START:
                begin
                    row_next  = '0;
                    col_next  = '0;
                    eh_next   = 1'b1;
                    vl_next   = '0;
                    tp_next   = '0;
                    zc_next   = '0;
                    done_next = 1'b0;
                end
                trpd_pkg::OP_BYTE:
                begin
                    if (!done_reg)
                    begin
                        if (cfg.compressed && eh_reg)
                        begin
                            if (vis == '0)
                            begin
                                // whole row trimmed, w >= 1 so one of the runs is nonzero
                                has_res = 1'b1;
                                finish  = 1'b1;
                                if (lead != '0 && trail != '0)
                                begin
                                    res.len0     = lead;
                                    res.two      = 1'b1;
                                    res.len1     = trail;
                                    res.row_end1 = 1'b1;
                                end
                                else
                                begin
                                    res.len0     = (lead != '0) ? lead : trail;
                                    res.row_end0 = 1'b1;
                                end
                            end
                            else
                            begin
                                has_res  = (lead != '0);
                                res.len0 = lead;
                                vl_next  = vis;
                                tp_next  = TW'(trail);
                                eh_next  = 1'b0;
                            end
                        end
                        else if (cfg.compressed || col_reg < w_col)
                        begin
                            has_res    = 1'b1;
                            res_map    = cfg.remap;
                            res.pixel0 = byte_value;
                            res.len0   = DW'(1);
                            if (cfg.remap && byte_value == '0 && zc_reg != '1)
                            begin
                                zc_next = zc_reg + ZW'(1);
                            end
                        end

                        if (cfg.compressed && !eh_reg)
                        begin
                            if (vl_reg <= DW'(1))
                            begin
                                finish = 1'b1;
                                if (tp_reg != '0)
                                begin
                                    res.two      = 1'b1;
                                    res.len1     = DW'(tp_reg);
                                    res.row_end1 = 1'b1;
                                end
                                else
                                begin
                                    res.row_end0 = 1'b1;
                                end
                            end
                            else
                            begin
                                vl_next = vl_reg - DW'(1);
                            end
                        end
                        else if (!cfg.compressed)
                        begin
                            // raw row: last pixel ends the row, padding bytes are dropped
                            res.row_end0 = (col_inc == w_col);
                            col_next     = col_inc;
                            finish       = (col_inc >= stride);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (finish)
        begin
            row_next = row_inc;
            col_next = '0;
            eh_next  = 1'b1;
            vl_next  = '0;
            tp_next  = '0;
            if (row_inc >= cfg.height)
            begin
                done_next = 1'b1;
            end
        end

        res.image_end0 = res.row_end0 && last_row;
        res.image_end1 = res.row_end1 && last_row;
        res.zero_count = zc_next;

        if (accept)
        begin
            stage_valid_next = has_res;
        end
        else if (push)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg         <= '0;
            col_reg         <= '0;
            eh_reg          <= 1'b1;
            vl_reg          <= '0;
            tp_reg          <= '0;
            zc_reg          <= '0;
            done_reg        <= 1'b0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg         <= row_next;
            col_reg         <= col_next;
            eh_reg          <= eh_next;
            vl_reg          <= vl_next;
            tp_reg          <= tp_next;
            zc_reg          <= zc_next;
            done_reg        <= done_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && has_res)
        begin
            stage_reg     <= res;
            stage_map_reg <= res_map;
        end
    end

    // table data is registered at the same edge that loads the stage and stays put while the stage waits
    always_comb
    begin
        push_entry = stage_reg;
        if (stage_map_reg)
        begin
            push_entry.pixel0 = ram_rdata;
        end
    end

endmodule

`default_nettype wire

@@ hdl/trpd_queue.sv @@
// short entry queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module trpd_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire trpd_pkg::entry_t  push_entry,
    output logic                   full,
    input  wire logic              pop,
    output trpd_pkg::entry_t       head,
    output logic                   empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    trpd_pkg::entry_t slots [DEPTH];

    logic [AW-1:0] wr_reg, wr_next;
    logic [AW-1:0] rd_reg, rd_next;
    logic [NW-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == NW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = slots[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_next = (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + AW'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + NW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

@@ hdl/trpd_back.sv @@
// back end: splits queued entries into runs behind the output register
`timescale 1ns / 1ps
`default_nettype none

module trpd_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire trpd_pkg::entry_t               head,
    input  wire logic                           empty,
    output logic                                pop,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [trpd_pkg::PIX_W-1:0]          pixel_value,
    output logic [trpd_pkg::DIM_W-1:0]          run_length,
    output logic                                row_end,
    output logic                                image_end,
    output logic                                last_of_item,
    output logic [trpd_pkg::ZC_W-1:0]           zero_remap_count
);

    logic out_valid_reg, out_valid_next;
    logic phase_reg, phase_next;
    logic load, take;

    logic [trpd_pkg::PIX_W-1:0] pix_reg;
    logic [trpd_pkg::DIM_W-1:0] len_reg;
    logic                       re_reg, ie_reg, last_reg;
    logic [trpd_pkg::ZC_W-1:0]  zc_reg;

    assign load = !out_valid_reg || !out_stall;
    assign take = load && !empty;

    always_comb
    begin
        out_valid_next = load ? !empty : out_valid_reg;
        phase_next     = phase_reg;
        pop            = 1'b0;
        if (take)
        begin
            // the first run of a two run entry leaves the entry at the head
            if (head.two && !phase_reg)
            begin
                phase_next = 1'b1;
            end
            else
            begin
                phase_next = 1'b0;
                pop        = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pix_reg  <= phase_reg ? '0 : head.pixel0;
            len_reg  <= phase_reg ? head.len1 : head.len0;
            re_reg   <= phase_reg ? head.row_end1 : head.row_end0;
            ie_reg   <= phase_reg ? head.image_end1 : head.image_end0;
            last_reg <= phase_reg || !head.two;
            zc_reg   <= head.zero_count;
        end
    end

    assign out_valid        = out_valid_reg;
    assign pixel_value      = pix_reg;
    assign run_length       = len_reg;
    assign row_end          = re_reg;
    assign image_end        = ie_reg;
    assign last_of_item     = last_reg;
    assign zero_remap_count = zc_reg;

endmodule

`default_nettype wire

@@ hdl/trimmed_row_pixel_decoder_core.sv @@
// top level of the trimmed row pixel decoder
`timescale 1ns / 1ps
`default_nettype none

// Decodes the byte stream of an 8-bit indexed image into pixel runs, either from
// trimmed rows (a header byte giving shifted leading and trailing zero counts,
// then only the visible pixels) or from raw rows padded to four bytes. One
// request is taken every clock cycle while in_stall is low. A request gives at
// most two runs and the output register hands out one run per cycle unless
// out_stall holds it, so a byte that gives two runs (a header with both counts
// and no visible pixels, or the last visible pixel followed by a trailing run)
// occupies the output for both runs in turn; the entry queue between the front
// end and the run splitter absorbs such bursts. A run passes through the front
// end stage, loaded together with the remap table read at the edge that takes
// its request, then the queue, then the output register. Table writes, start of
// image and ignored bytes give no run. Remap entries must be written before a
// remapped pixel reads them.
module trimmed_row_pixel_decoder_core #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [trpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [trpd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [1:0]                        operation,
    input  wire logic [trpd_pkg::PIX_W-1:0]        byte_value,
    input  wire logic [trpd_pkg::PIX_W-1:0]        table_index,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [trpd_pkg::PIX_W-1:0]             pixel_value,
    output logic [trpd_pkg::DIM_W-1:0]             run_length,
    output logic                                   row_end,
    output logic                                   image_end,
    output logic                                   last_of_item,
    output logic [trpd_pkg::ZC_W-1:0]              zero_remap_count
);

    localparam int DW     = trpd_pkg::DIM_W;
    localparam int DIM_MX = (1 << DW) - 1;
    localparam logic [DW-1:0] W_LIMIT = DW'((MAX_WIDTH > DIM_MX) ? DIM_MX : MAX_WIDTH);
    localparam logic [DW-1:0] H_LIMIT = DW'((MAX_HEIGHT > DIM_MX) ? DIM_MX : MAX_HEIGHT);

    logic [DW-1:0] width_reg, height_reg;
    logic          comp_reg, remap_reg;
    logic [1:0]    lshift_reg, tshift_reg;

    trpd_pkg::cfg_t   cfg;
    trpd_pkg::entry_t push_entry, head;
    logic             ram_we, ram_re, push, pop, q_full, q_empty;
    logic [trpd_pkg::PIX_W-1:0] ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DW'(1);
            height_reg <= DW'(1);
            comp_reg   <= 1'b0;
            lshift_reg <= 2'd0;
            tshift_reg <= 2'd0;
            remap_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                trpd_pkg::REG_IMAGE_WIDTH:     width_reg  <= cfg_data[DW-1:0];
                trpd_pkg::REG_IMAGE_HEIGHT:    height_reg <= cfg_data[DW-1:0];
                trpd_pkg::REG_COMPRESSED_MODE: comp_reg   <= cfg_data[0];
                trpd_pkg::REG_LEADING_SHIFT:   lshift_reg <= cfg_data[1:0];
                trpd_pkg::REG_TRAILING_SHIFT:  tshift_reg <= cfg_data[1:0];
                trpd_pkg::REG_REMAP_ENABLE:    remap_reg  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // zero acts as one, anything above the limit acts as the limit
    always_comb
    begin
        cfg.width       = (width_reg == '0) ? DW'(1)
                        : ((width_reg > W_LIMIT) ? W_LIMIT : width_reg);
        cfg.height      = (height_reg == '0) ? DW'(1)
                        : ((height_reg > H_LIMIT) ? H_LIMIT : height_reg);
        cfg.compressed  = comp_reg;
        cfg.lead_shift  = lshift_reg;
        cfg.trail_shift = tshift_reg;
        cfg.remap       = remap_reg;
    end

    trpd_ram #(
        .WIDTH (trpd_pkg::PIX_W),
        .DEPTH (trpd_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (table_index),
        .wdata (byte_value),
        .re    (ram_re),
        .raddr (byte_value),
        .rdata (ram_rdata)
    );

    trpd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .byte_value  (byte_value),
        .ram_we      (ram_we),
        .ram_re      (ram_re),
        .ram_rdata   (ram_rdata),
        .q_full      (q_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    trpd_queue #(
        .DEPTH (trpd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty)
    );

    trpd_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head             (head),
        .empty            (q_empty),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .pixel_value      (pixel_value),
        .run_length       (run_length),
        .row_end          (row_end),
        .image_end        (image_end),
        .last_of_item     (last_of_item),
        .zero_remap_count (zero_remap_count)
    );

    // the second run of a request follows the first without a gap
    a_second_run_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_item |=> out_valid)
        else $error("second run of a request did not follow");

    a_image_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && image_end |-> row_end)
        else $error("image end without row end");

    a_run_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> run_length != '0)
        else $error("empty run");

    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_full && q_empty) && !(pop && q_empty))
        else $error("queue status inconsistent");

endmodule

`default_nettype wire
